>>> rtl/bfsa_pkg.sv
// shared types, codes and defaults for the best-fit segment allocator
package bfsa_pkg;

   localparam int HEAP_BYTES_DEF   = 4096;
   localparam int MAX_SEGMENTS_DEF = 64;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NOFIT   = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;
   localparam logic [1:0] STATUS_BADADDR = 2'd3;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_MOVE,
      ST_WR_HI,
      ST_WR_LO,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic fit_found;
      logic pos_found;
      logic prev_free;
      logic next_free;
   } scan_flags_type;

endpackage

>>> rtl/bfsa_seg_mem.sv
// segment table memory, one write and one registered read per cycle
module bfsa_seg_mem import bfsa_pkg::*; #(
   parameter int DATA_W = 26,
   parameter int DEPTH  = MAX_SEGMENTS_DEF,
   parameter int ADDR_W = $clog2(MAX_SEGMENTS_DEF)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/bfsa_scan.sv
// table scan: best-fit search for allocate, owner and neighbors for free
module bfsa_scan import bfsa_pkg::*; #(
   parameter int AW = 12,
   parameter int LW = 13,
   parameter int IW = 6
) (
   input  logic           clock,
   input  logic           clear,
   input  logic           dvalid,
   input  logic [IW-1:0]  didx,
   input  logic [AW-1:0]  dstart,
   input  logic [LW-1:0]  dlen,
   input  logic           dused,
   input  logic [LW-1:0]  size,
   input  logic [AW-1:0]  addr,
   output scan_flags_type flags,
   output logic [IW-1:0]  best_idx,
   output logic [LW-1:0]  best_left,
   output logic [AW-1:0]  best_start,
   output logic [IW-1:0]  pos_idx,
   output logic [LW-1:0]  pos_len,
   output logic [AW-1:0]  prev_start,
   output logic [LW-1:0]  prev_len,
   output logic [LW-1:0]  next_len
);

   logic          fit_found_ff, pos_found_ff, next_seen_ff;
   logic [IW-1:0] best_idx_ff, pos_idx_ff;
   logic [LW-1:0] best_left_ff, pos_len_ff, prev_len_ff, next_len_ff, last_len_ff;
   logic [AW-1:0] best_start_ff, prev_start_ff, last_start_ff;
   logic          prev_used_ff, next_used_ff, last_used_ff;
   logic [LW-1:0] left;
   logic          fits;

   assign fits = !dused && (dlen >= size);
   assign left = dlen - size;

   always_ff @(posedge clock) begin
      if (clear) begin
         fit_found_ff <= 1'b0;
         pos_found_ff <= 1'b0;
         next_seen_ff <= 1'b0;
      end else if (dvalid) begin
         if (fits && (!fit_found_ff || left < best_left_ff)) begin
            fit_found_ff  <= 1'b1;
            best_idx_ff   <= didx;
            best_left_ff  <= left;
            best_start_ff <= dstart;
         end
         if (!pos_found_ff && dused && dstart == addr) begin
            pos_found_ff  <= 1'b1;
            pos_idx_ff    <= didx;
            pos_len_ff    <= dlen;
            prev_used_ff  <= last_used_ff;
            prev_len_ff   <= last_len_ff;
            prev_start_ff <= last_start_ff;
         end else if (pos_found_ff && !next_seen_ff) begin
            next_seen_ff <= 1'b1;
            next_used_ff <= dused;
            next_len_ff  <= dlen;
         end
         last_used_ff  <= dused;
         last_len_ff   <= dlen;
         last_start_ff <= dstart;
      end
   end

   assign flags.fit_found = fit_found_ff;
   assign flags.pos_found = pos_found_ff;
   assign flags.prev_free = (pos_idx_ff != '0) && !prev_used_ff;
   assign flags.next_free = next_seen_ff && !next_used_ff;
   assign best_idx   = best_idx_ff;
   assign best_left  = best_left_ff;
   assign best_start = best_start_ff;
   assign pos_idx    = pos_idx_ff;
   assign pos_len    = pos_len_ff;
   assign prev_start = prev_start_ff;
   assign prev_len   = prev_len_ff;
   assign next_len   = next_len_ff;

endmodule

>>> rtl/best_fit_segment_allocator_top.sv
// best-fit segment allocator top level: sequencer, move unit and response register
//
//  channel  | handshake            | payload
//  req      | req_valid/req_ready  | req_command, req_request_size, req_free_address
//  rsp      | rsp_valid/rsp_ready  | rsp_block_address, rsp_status
//
// a request with N live segments passes through idle, which takes it, a scan
// of the table through the registered memory read, decide, an optional shift
// of entries for a split or a merge, then up to two entry writes and the
// response load
// after reset the init state writes the initial whole-heap segment before req_ready
// a new request is taken while an earlier response still waits on rsp_ready

module best_fit_segment_allocator_top import bfsa_pkg::*; #(
   parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
   parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
   localparam int AW = $clog2(HEAP_BYTES),
   localparam int LW = AW + 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          req_command,
   input  logic [LW-1:0] req_request_size,
   input  logic [AW-1:0] req_free_address,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [AW-1:0] rsp_block_address,
   output logic [1:0]    rsp_status
);

   localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int CW = $clog2(MAX_SEGMENTS + 1);
   localparam int DW = 1 + LW + AW;

   // table entry word is {used, length, start}
   localparam logic [DW-1:0] INIT_WORD = {1'b0, LW'(HEAP_BYTES), {AW{1'b0}}};

   state_type state_ff, state_in;

   logic [CW-1:0] count_ff, count_in;
   logic          cmd_ff;
   logic [LW-1:0] size_ff;
   logic [AW-1:0] addr_ff;

   // scan read pipeline
   logic [CW-1:0] scan_cnt_ff, scan_cnt_in;
   logic          dvalid_ff, dvalid_in;
   logic [IW-1:0] didx_ff, didx_in;

   // move unit
   logic [IW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] moves_ff, moves_in;
   logic          up_ff, up_in;
   logic [1:0]    gap_ff, gap_in;
   logic          wb_pend_ff, wb_pend_in;
   logic [IW-1:0] wb_addr_ff, wb_addr_in;

   // deferred entry writes
   logic          hi_en_ff, hi_en_in, lo_en_ff, lo_en_in;
   logic [IW-1:0] hi_idx_ff, hi_idx_in, lo_idx_ff, lo_idx_in;
   logic [DW-1:0] hi_word_ff, hi_word_in, lo_word_ff, lo_word_in;

   // result
   logic [AW-1:0] res_addr_ff, res_addr_in;
   logic [1:0]    res_status_ff, res_status_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0] rsp_addr_ff, rsp_addr_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;

   // memory port
   logic          mem_we;
   logic [IW-1:0] mem_waddr, mem_raddr;
   logic [DW-1:0] mem_wdata, mem_rdata;

   // scan results
   scan_flags_type flags;
   logic [IW-1:0]  best_idx, pos_idx;
   logic [LW-1:0]  best_left, pos_len, prev_len, next_len;
   logic [AW-1:0]  best_start, prev_start;
   logic [LW-1:0]  merged_len;
   logic [CW-1:0]  first_rm, rm_cnt;
   logic           scan_done;

   bfsa_seg_mem #(
      .DATA_W (DW),
      .DEPTH  (MAX_SEGMENTS),
      .ADDR_W (IW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   bfsa_scan #(
      .AW (AW),
      .LW (LW),
      .IW (IW)
   ) u_scan (
      .clock      (clock),
      .clear      (state_ff == ST_IDLE),
      .dvalid     (dvalid_ff),
      .didx       (didx_ff),
      .dstart     (mem_rdata[AW-1:0]),
      .dlen       (mem_rdata[AW+LW-1:AW]),
      .dused      (mem_rdata[DW-1]),
      .size       (size_ff),
      .addr       (addr_ff),
      .flags      (flags),
      .best_idx   (best_idx),
      .best_left  (best_left),
      .best_start (best_start),
      .pos_idx    (pos_idx),
      .pos_len    (pos_len),
      .prev_start (prev_start),
      .prev_len   (prev_len),
      .next_len   (next_len)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign scan_done = (scan_cnt_ff == count_ff) && !dvalid_ff;

   // free: size of the merged segment and what leaves the table
   assign merged_len = flags.prev_free
                       ? prev_len + pos_len + (flags.next_free ? next_len : '0)
                       : pos_len + (flags.next_free ? next_len : '0);
   assign first_rm   = flags.prev_free ? CW'(pos_idx) : CW'(pos_idx) + CW'(1);
   assign rm_cnt     = CW'(flags.prev_free) + CW'(flags.next_free);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_done) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (moves_in != '0)     state_in = ST_MOVE;
            else if (hi_en_in)      state_in = ST_WR_HI;
            else if (lo_en_in)      state_in = ST_WR_LO;
            else                    state_in = ST_DONE;
         end
         ST_MOVE: begin
            if (moves_ff == '0 && !wb_pend_ff) begin
               if (hi_en_ff)      state_in = ST_WR_HI;
               else if (lo_en_ff) state_in = ST_WR_LO;
               else               state_in = ST_DONE;
            end
         end
         ST_WR_HI: state_in = lo_en_ff ? ST_WR_LO : ST_DONE;
         ST_WR_LO: state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory port
   always_comb begin
      count_in      = count_ff;
      scan_cnt_in   = scan_cnt_ff;
      dvalid_in     = 1'b0;
      didx_in       = didx_ff;
      rd_ptr_in     = rd_ptr_ff;
      moves_in      = moves_ff;
      up_in         = up_ff;
      gap_in        = gap_ff;
      wb_pend_in    = 1'b0;
      wb_addr_in    = wb_addr_ff;
      hi_en_in      = hi_en_ff;
      hi_idx_in     = hi_idx_ff;
      hi_word_in    = hi_word_ff;
      lo_en_in      = lo_en_ff;
      lo_idx_in     = lo_idx_ff;
      lo_word_in    = lo_word_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = lo_word_ff;
      mem_raddr     = '0;

      case (state_ff)
         ST_INIT: begin
            mem_we    = 1'b1;
            mem_wdata = INIT_WORD;
         end
         ST_IDLE: begin
            scan_cnt_in = '0;
         end
         ST_SCAN: begin
            mem_raddr = scan_cnt_ff[IW-1:0];
            if (scan_cnt_ff != count_ff) begin
               dvalid_in   = 1'b1;
               didx_in     = scan_cnt_ff[IW-1:0];
               scan_cnt_in = scan_cnt_ff + CW'(1);
            end
         end
         ST_DECIDE: begin
            moves_in      = '0;
            hi_en_in      = 1'b0;
            lo_en_in      = 1'b0;
            res_addr_in   = '0;
            res_status_in = STATUS_OK;
            if (cmd_ff == CMD_ALLOC) begin
               if (size_ff == '0 || !flags.fit_found) begin
                  res_status_in = STATUS_NOFIT;
               end else if (best_left == '0) begin
                  // exact fit, only mark used
                  lo_en_in    = 1'b1;
                  lo_idx_in   = best_idx;
                  lo_word_in  = {1'b1, size_ff, best_start};
                  res_addr_in = best_start;
               end else if (count_ff == CW'(MAX_SEGMENTS)) begin
                  res_status_in = STATUS_FULL;
               end else begin
                  // split: open a slot above best, then write both halves
                  moves_in    = count_ff - CW'(best_idx);
                  up_in       = 1'b1;
                  gap_in      = 2'd1;
                  rd_ptr_in   = IW'(count_ff - CW'(1));
                  hi_en_in    = 1'b1;
                  hi_idx_in   = IW'(CW'(best_idx) + CW'(1));
                  hi_word_in  = {1'b0, best_left, best_start + AW'(size_ff)};
                  lo_en_in    = 1'b1;
                  lo_idx_in   = best_idx;
                  lo_word_in  = {1'b1, size_ff, best_start};
                  count_in    = count_ff + CW'(1);
                  res_addr_in = best_start;
               end
            end else begin
               if (!flags.pos_found) begin
                  res_status_in = STATUS_BADADDR;
               end else begin
                  lo_en_in = 1'b1;
                  if (flags.prev_free) begin
                     lo_idx_in  = IW'(CW'(pos_idx) - CW'(1));
                     lo_word_in = {1'b0, merged_len, prev_start};
                  end else begin
                     lo_idx_in  = pos_idx;
                     lo_word_in = {1'b0, merged_len, addr_ff};
                  end
                  // close the gap left by merged neighbors
                  if (rm_cnt != '0) begin
                     moves_in = count_ff - first_rm - rm_cnt;
                  end
                  up_in     = 1'b0;
                  gap_in    = 2'(rm_cnt);
                  rd_ptr_in = IW'(first_rm + rm_cnt);
                  count_in  = count_ff - rm_cnt;
               end
            end
         end
         ST_MOVE: begin
            mem_raddr = rd_ptr_ff;
            if (wb_pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = wb_addr_ff;
               mem_wdata = mem_rdata;
            end
            if (moves_ff != '0) begin
               wb_pend_in = 1'b1;
               moves_in   = moves_ff - CW'(1);
               if (up_ff) begin
                  wb_addr_in = IW'({1'b0, rd_ptr_ff} + (IW+1)'(1));
                  rd_ptr_in  = rd_ptr_ff - IW'(1);
               end else begin
                  wb_addr_in = IW'({1'b0, rd_ptr_ff} - (IW+1)'(gap_ff));
                  rd_ptr_in  = rd_ptr_ff + IW'(1);
               end
            end
         end
         ST_WR_HI: begin
            mem_we    = 1'b1;
            mem_waddr = hi_idx_ff;
            mem_wdata = hi_word_ff;
         end
         ST_WR_LO: begin
            mem_we    = 1'b1;
            mem_waddr = lo_idx_ff;
            mem_wdata = lo_word_ff;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = res_addr_ff;
               rsp_status_in = res_status_ff;
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         count_ff     <= CW'(1);
         dvalid_ff    <= 1'b0;
         wb_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dvalid_ff    <= dvalid_in;
         wb_pend_ff   <= wb_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff  <= req_command;
         size_ff <= req_request_size;
         addr_ff <= req_free_address;
      end
      scan_cnt_ff   <= scan_cnt_in;
      didx_ff       <= didx_in;
      rd_ptr_ff     <= rd_ptr_in;
      moves_ff      <= moves_in;
      up_ff         <= up_in;
      gap_ff        <= gap_in;
      wb_addr_ff    <= wb_addr_in;
      hi_en_ff      <= hi_en_in;
      hi_idx_ff     <= hi_idx_in;
      hi_word_ff    <= hi_word_in;
      lo_en_ff      <= lo_en_in;
      lo_idx_ff     <= lo_idx_in;
      lo_word_ff    <= lo_word_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_block_address = rsp_addr_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

>>> tb/testbench.sv
// testbench for the best-fit segment allocator: queued driver, clocked monitor, table predictor
module testbench;
   import bfsa_pkg::*;

   localparam int HEAP = 4096;
   localparam int SEGS = 64;

   typedef struct packed {
      logic        command;
      logic [12:0] size;
      logic [11:0] address;
   } request_type;

   typedef struct packed {
      logic [11:0] block_address;
      logic [1:0]  status;
   } response_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_command = CMD_ALLOC;
   logic [12:0] req_request_size = '0;
   logic [11:0] req_free_address = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [11:0] rsp_block_address;
   logic [1:0]  rsp_status;

   best_fit_segment_allocator_top i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_command(req_command), .req_request_size(req_request_size),
      .req_free_address(req_free_address),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_block_address(rsp_block_address), .rsp_status(rsp_status)
   );

   always #5 clock = ~clock;

   // predictor copy of the segment table
   logic [11:0] seg_start [SEGS];
   logic [12:0] seg_len   [SEGS];
   logic        seg_used  [SEGS];
   int          seg_count;

   request_type  pending_requests [$];
   response_type expected_responses [$];
   int        errors = 0;
   int        responses_seen = 0;
   int        send_idle_pct = 0;
   int        recv_stall_pct = 0;
   int        status_hits [4] = '{0, 0, 0, 0};

   // live allocations the stimulus can pick from for well-formed frees
   logic [11:0] live_blocks [$];

   // handshake sampled at the rising edge, used by the driver at the next falling edge
   logic req_ready_seen = 1'b0;
   request_type accepted;
   logic live_candidates_push = 1'b0;

   function automatic void table_reset();
      for (int k = 0; k < SEGS; k++) begin
         seg_start[k] = '0;
         seg_len[k] = '0;
         seg_used[k] = 1'b0;
      end
      seg_len[0] = 13'(HEAP);
      seg_count = 1;
   endfunction

   function automatic void table_remove(int pos);
      for (int k = pos; k + 1 < seg_count; k++) begin
         seg_start[k] = seg_start[k + 1];
         seg_len[k] = seg_len[k + 1];
         seg_used[k] = seg_used[k + 1];
      end
      seg_count--;
      seg_start[seg_count] = '0;
      seg_len[seg_count] = '0;
      seg_used[seg_count] = 1'b0;
   endfunction

   // best-fit allocate or coalescing free, returns the expected response
   function automatic response_type allocator_predict(request_type r);
      response_type rsp;
      int best;
      int best_left;
      int pos;
      bit found;
      rsp = '{block_address: '0, status: STATUS_OK};
      found = 0;
      best = 0;
      best_left = 0;
      pos = 0;
      if (r.command == CMD_ALLOC) begin
         if (r.size == 0) begin
            rsp.status = STATUS_NOFIT;
            return rsp;
         end
         for (int k = 0; k < seg_count; k++) begin
            if (!seg_used[k] && seg_len[k] >= r.size) begin
               if (!found || int'(seg_len[k] - r.size) < best_left) begin
                  found = 1;
                  best = k;
                  best_left = int'(seg_len[k] - r.size);
               end
            end
         end
         if (!found) begin
            rsp.status = STATUS_NOFIT;
         end else if (best_left == 0) begin
            seg_used[best] = 1'b1;
            rsp.block_address = seg_start[best];
         end else if (seg_count >= SEGS) begin
            rsp.status = STATUS_FULL;
         end else begin
            for (int k = seg_count; k > best; k--) begin
               seg_start[k] = seg_start[k - 1];
               seg_len[k] = seg_len[k - 1];
               seg_used[k] = seg_used[k - 1];
            end
            seg_count++;
            seg_len[best] = r.size;
            seg_used[best] = 1'b1;
            seg_start[best + 1] = seg_start[best] + r.size[11:0];
            seg_len[best + 1] = 13'(best_left);
            seg_used[best + 1] = 1'b0;
            rsp.block_address = seg_start[best];
         end
      end else begin
         for (int k = 0; k < seg_count; k++) begin
            if (!found && seg_used[k] && seg_start[k] == r.address) begin
               pos = k;
               found = 1;
            end
         end
         if (!found) begin
            rsp.status = STATUS_BADADDR;
            return rsp;
         end
         seg_used[pos] = 1'b0;
         if (pos + 1 < seg_count && !seg_used[pos + 1]) begin
            seg_len[pos] += seg_len[pos + 1];
            table_remove(pos + 1);
         end
         if (pos > 0 && !seg_used[pos - 1]) begin
            seg_len[pos - 1] += seg_len[pos];
            table_remove(pos);
         end
      end
      return rsp;
   endfunction

   // driver: presents queued requests at the falling edge, idles at random
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready_seen) begin
            // previous request taken at the last rising edge
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               {req_command, req_request_size, req_free_address} <= pending_requests.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end else if (!req_valid) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               {req_command, req_request_size, req_free_address} <= pending_requests.pop_front();
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // monitor: predicts on each accepted request, checks each accepted response
   always @(posedge clock) begin
      req_ready_seen <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready) begin
            accepted = '{command: req_command, size: req_request_size,
                         address: req_free_address};
            expected_responses.push_back(allocator_predict(accepted));
         end
         if (rsp_valid && rsp_ready) begin
            responses_seen++;
            if (expected_responses.size() == 0) begin
               $error("response with no request outstanding: address %0d status %0d",
                      rsp_block_address, rsp_status);
               errors++;
            end else begin
               response_type want;
               want = expected_responses.pop_front();
               status_hits[want.status]++;
               if (rsp_block_address !== want.block_address) begin
                  $error("block_address mismatch: expected %0d actual %0d",
                         want.block_address, rsp_block_address);
                  errors++;
               end
               if (rsp_status !== want.status) begin
                  $error("status mismatch: expected %0d actual %0d",
                         want.status, rsp_status);
                  errors++;
               end
            end
         end
      end
   end

   // request builders for the stimulus
   function automatic request_type alloc_req(int size);
      request_type r;
      r.command = CMD_ALLOC;
      r.size = 13'(size);
      r.address = 12'($urandom);
      return r;
   endfunction

   function automatic request_type free_req(int address);
      request_type r;
      r.command = CMD_FREE;
      r.size = 13'($urandom);
      r.address = 12'(address);
      return r;
   endfunction

   task automatic wait_drained();
      while (pending_requests.size() > 0 || req_valid || expected_responses.size() > 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   // random request mix fed a few at a time so frees see the live blocks
   task automatic queue_random(int count);
      int pick;
      int idx;
      for (int n = 0; n < count; n++) begin
         while (pending_requests.size() > 1)
            @(posedge clock);
         pick = $urandom_range(99);
         if (pick < 45) begin
            // small sizes keep the table busy, some large to hit no-fit
            if ($urandom_range(9) == 0)
               pending_requests.push_back(alloc_req($urandom_range(8191)));
            else
               pending_requests.push_back(alloc_req($urandom_range(1, 128)));
         end else if (pick < 85 && live_blocks.size() > 0) begin
            idx = $urandom_range(live_blocks.size() - 1);
            pending_requests.push_back(free_req(live_blocks[idx]));
            live_blocks.delete(idx);
         end else begin
            // noise: random address, usually not a live block
            pending_requests.push_back(free_req($urandom_range(4095)));
         end
      end
   endtask

   // live block tracking follows the actual stream of predicted allocations
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready && req_command == CMD_ALLOC)
         live_candidates_push <= 1'b1;
      else
         live_candidates_push <= 1'b0;
   end
   always @(negedge clock) begin
      if (live_candidates_push && expected_responses.size() > 0
          && expected_responses[$].status == STATUS_OK)
         live_blocks.push_back(expected_responses[$].block_address);
   end

   initial begin
      int pct [4][2];
      pct = '{'{0, 0}, '{73, 0}, '{0, 73}, '{33, 33}};
      table_reset();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: zero size, oversize, whole heap exact fit, bad frees, fill the table
      pending_requests.push_back(alloc_req(0));
      pending_requests.push_back(alloc_req(8191));
      pending_requests.push_back(alloc_req(4097));
      pending_requests.push_back(alloc_req(4096));
      pending_requests.push_back(alloc_req(1));
      pending_requests.push_back(free_req(0));
      pending_requests.push_back(free_req(0));
      pending_requests.push_back(free_req(4095));
      pending_requests.push_back(alloc_req(1));
      for (int k = 1; k < 64; k++)
         pending_requests.push_back(alloc_req(1));
      wait_drained();
      // table now full: split fails, exact fit on a freed hole still works
      pending_requests.push_back(alloc_req(2));
      pending_requests.push_back(free_req(5));
      pending_requests.push_back(free_req(6));
      pending_requests.push_back(free_req(4));
      pending_requests.push_back(alloc_req(3));
      pending_requests.push_back(alloc_req(2048));
      for (int k = 0; k < 64; k++)
         pending_requests.push_back(free_req(k));
      pending_requests.push_back(free_req(4095));
      wait_drained();
      live_blocks.delete();

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = pct[phase][0];
         recv_stall_pct = pct[phase][1];
         queue_random(150);
         wait_drained();
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;

      $display("covered %0d responses: ok %0d, no fit %0d, table full %0d, bad address %0d",
               responses_seen, status_hits[0], status_hits[1], status_hits[2], status_hits[3]);
      $display("idling phases: none, sender, receiver, both");
      if (errors == 0 && expected_responses.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // watchdog: time limit for about 750 requests, stalls included
   initial begin
      #20000000;
      $display("FAILURE");
      $finish;
   end
endmodule

>>> filelist.f
rtl/bfsa_pkg.sv
rtl/bfsa_seg_mem.sv
rtl/bfsa_scan.sv
rtl/best_fit_segment_allocator_top.sv
tb/testbench.sv
